FILE: hw/rtl/mpwc_pkg.sv
`timescale 1ns / 1ps
// Package for the multichannel pulse width capture block.
// Holds the channel count, field widths, command codes and shared types; no dependencies.
package mpwc_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int TIME_W   = 8;
  localparam int CONF_W   = 4;
  localparam int COUNT_W  = 16;
  localparam int PIN_W    = 8;
  localparam int SEL_W    = 3;
  localparam int CMD_W    = 2;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int ADDR_W     = 4;

  localparam logic [TIME_W-1:0] CENTER_RST  = 8'd23;
  localparam logic [CONF_W-1:0] LIMIT_RST   = 4'd8;
  localparam logic [TIME_W-1:0] MISSING_RST = 8'h80;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_CENTER  = 2'd0,
    REG_LIMIT   = 2'd1,
    REG_MISSING = 2'd2,
    REG_UNUSED  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_READ = 2'd2,
    ST_EMIT = 2'd3
  } seq_state_e;

  typedef enum logic {
    ALU_SAMPLE = 1'b0,
    ALU_EXPIRE = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic [TIME_W-1:0] center_offset;
    logic [CONF_W-1:0] good_limit;
    logic [TIME_W-1:0] missing_code;
  } cfg_t;

  typedef struct packed {
    logic              rise_we;
    logic              width_we;
    logic              conf_we;
    logic              fall;
    logic [TIME_W-1:0] rise_d;
    logic [TIME_W-1:0] width_d;
    logic [CONF_W-1:0] conf_d;
  } alu_res_t;

endpackage

FILE: hw/rtl/multichannel_pulse_width_capture.sv
`timescale 1ns / 1ps
// Pin sample and tick walk every channel, one channel per cycle through the shared update
// unit; a read looks up one channel; an unused command goes straight to the result.
// One beat at a time: input not ready until the result is registered.
// Reset (async, active low) clears all channel state, the cycle counter and the output
// valid flag, and loads the configuration defaults.
module multichannel_pulse_width_capture (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] pin_levels, [15:8] timer_now, [18:16] channel
  input  logic [1:0]  s_axis_tuser,  // [1:0] command
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [7:0] reading, [8] present, [24:9] cycle_count
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mpwc_pkg::*;

  cfg_t       cfg;
  seq_state_e state_q, state_d;

  // item registers
  cmd_e              cmd_q;
  logic [PIN_W-1:0]  prev_q, levels_q;
  logic [TIME_W-1:0] now_q;
  logic [CH_W-1:0]   idx_q;
  logic              sel_ok_q;

  // channel state
  logic [PIN_W-1:0]  last_levels_q;
  logic [TIME_W-1:0] rise_q  [CHANNELS];
  logic [TIME_W-1:0] width_q [CHANNELS];
  logic [CONF_W-1:0] conf_q  [CHANNELS];
  logic [COUNT_W-1:0] edge_cycles_q;

  // result staging and output register
  logic [TIME_W-1:0]  reading_q;
  logic               present_q;
  logic               m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic     accept, scan_en, read_en, emit_en, last_ch;
  alu_op_e  alu_op;
  alu_res_t alu_res;
  logic [TIME_W-1:0] cur_rise, cur_width;
  logic [CONF_W-1:0] cur_conf;
  logic [CONF_W-1:0] half_limit;

  mpwc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign last_ch       = (idx_q == CH_W'(CHANNELS - 1));

  // single address into the channel state: the scan counter, or the read channel
  assign cur_rise  = rise_q[idx_q];
  assign cur_width = width_q[idx_q];
  assign cur_conf  = conf_q[idx_q];
  assign half_limit = cfg.good_limit >> 1;

  assign alu_op = (cmd_q == CMD_TICK) ? ALU_EXPIRE : ALU_SAMPLE;

  mpwc_alu u_alu (
    .op_i     (alu_op),
    .changed_i(prev_q[idx_q] ^ levels_q[idx_q]),
    .level_i  (levels_q[idx_q]),
    .now_i    (now_q),
    .rise_i   (cur_rise),
    .conf_i   (cur_conf),
    .center_i (cfg.center_offset),
    .limit_i  (cfg.good_limit),
    .res_o    (alu_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(s_axis_tuser))
            CMD_SAMPLE, CMD_TICK: state_d = ST_SCAN;
            CMD_READ:             state_d = ST_READ;
            default:              state_d = ST_EMIT;
          endcase
        end
      end
      ST_SCAN: if (last_ch) state_d = ST_EMIT;
      ST_READ: state_d = ST_EMIT;
      ST_EMIT: if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    scan_en = 1'b0;
    read_en = 1'b0;
    emit_en = 1'b0;
    unique case (state_q)
      ST_SCAN: scan_en = 1'b1;
      ST_READ: read_en = 1'b1;
      ST_EMIT: emit_en = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // capture the item; a sample's pin byte becomes the new history right away
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_levels_q <= '0;
      cmd_q         <= CMD_NONE;
      idx_q         <= '0;
    end else if (accept) begin
      cmd_q <= cmd_e'(s_axis_tuser);
      if (cmd_e'(s_axis_tuser) == CMD_SAMPLE) begin
        last_levels_q <= s_axis_tdata[7:0];
      end
      // reads address the requested channel, scans start at channel 0
      if (cmd_e'(s_axis_tuser) == CMD_READ) begin
        idx_q <= s_axis_tdata[16 +: CH_W];
      end else begin
        idx_q <= '0;
      end
    end else if (scan_en && !last_ch) begin
      idx_q <= idx_q + CH_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_q   <= last_levels_q;
      levels_q <= s_axis_tdata[7:0];
      now_q    <= s_axis_tdata[15:8];
      sel_ok_q <= ({1'b0, s_axis_tdata[18:16]} < 4'(CHANNELS));
    end
  end

  // per-channel state, written through the shared unit one channel per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rise_q[i]  <= '0;
        width_q[i] <= '0;
        conf_q[i]  <= '0;
      end
      edge_cycles_q <= '0;
    end else if (scan_en) begin
      if (alu_res.rise_we)  rise_q[idx_q]  <= alu_res.rise_d;
      if (alu_res.width_we) width_q[idx_q] <= alu_res.width_d;
      if (alu_res.conf_we)  conf_q[idx_q]  <= alu_res.conf_d;
      // channel 0 falling edges count whole servo cycles
      if (alu_res.fall && idx_q == '0) begin
        edge_cycles_q <= edge_cycles_q + COUNT_W'(1);
      end
    end
  end

  // read result; everything else reports zero reading and not present
  always_ff @(posedge clk_i) begin
    if (accept) begin
      reading_q <= '0;
      present_q <= 1'b0;
    end else if (read_en) begin
      if (sel_ok_q && cur_conf >= half_limit) begin
        reading_q <= cur_width;
        present_q <= 1'b1;
      end else begin
        reading_q <= cfg.missing_code;
        present_q <= 1'b0;
      end
    end
  end

  // output register: hold the beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit_en) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      m_data_q <= {7'd0, edge_cycles_q, present_q, reading_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

FILE: hw/rtl/mpwc_cfg.sv
`timescale 1ns / 1ps
// Configuration registers behind an APB-style port.
// Depends on mpwc_pkg for register codes, widths and reset values.
module mpwc_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mpwc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output mpwc_pkg::cfg_t             cfg_o
);
  import mpwc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e sel;
  logic     wr_en;

  assign pready = 1'b1;
  assign sel    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        REG_CENTER:  cfg_d.center_offset = pwdata[TIME_W-1:0];
        REG_LIMIT:   cfg_d.good_limit    = pwdata[CONF_W-1:0];
        REG_MISSING: cfg_d.missing_code  = pwdata[TIME_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_CENTER:  prdata = {24'd0, cfg_q.center_offset};
      REG_LIMIT:   prdata = {28'd0, cfg_q.good_limit};
      REG_MISSING: prdata = {24'd0, cfg_q.missing_code};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_offset <= CENTER_RST;
      cfg_q.good_limit    <= LIMIT_RST;
      cfg_q.missing_code  <= MISSING_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/mpwc_alu.sv
`timescale 1ns / 1ps
// Shared per-channel update unit: edge handling and confidence aging.
// Depends on mpwc_pkg for the operation code and result struct.
module mpwc_alu (
  input  mpwc_pkg::alu_op_e                 op_i,
  input  logic                              changed_i,
  input  logic                              level_i,
  input  logic [mpwc_pkg::TIME_W-1:0]       now_i,
  input  logic [mpwc_pkg::TIME_W-1:0]       rise_i,
  input  logic [mpwc_pkg::CONF_W-1:0]       conf_i,
  input  logic [mpwc_pkg::TIME_W-1:0]       center_i,
  input  logic [mpwc_pkg::CONF_W-1:0]       limit_i,
  output mpwc_pkg::alu_res_t                res_o
);
  import mpwc_pkg::*;

  logic [TIME_W-1:0] width;

  // wraps mod 256; the result is read as signed
  assign width = now_i - rise_i - center_i;

  always_comb begin
    res_o = '0;
    res_o.rise_d = now_i;
    unique case (op_i)
      ALU_SAMPLE: begin
        res_o.width_d = width;
        res_o.conf_d  = conf_i + CONF_W'(1);
        if (changed_i) begin
          if (level_i) begin
            res_o.rise_we = 1'b1;
          end else begin
            res_o.fall     = 1'b1;
            res_o.width_we = 1'b1;
            res_o.conf_we  = (conf_i < limit_i);
          end
        end
      end
      ALU_EXPIRE: begin
        res_o.width_d = '0;
        res_o.conf_d  = conf_i - CONF_W'(1);
        res_o.width_we = (conf_i == CONF_W'(1));
        res_o.conf_we  = (conf_i != '0);
      end
      default: res_o = '0;
    endcase
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for multichannel_pulse_width_capture: a predictor tracks each channel's
// rise stamp, width and confidence, and every result beat is checked against it.
// Depends on mpwc_pkg and the block's RTL only.
module testbench;
  import mpwc_pkg::*;

  // Give up after this many cycles in which no beat and no register write moves.
  localparam int STALL_LIMIT = 4000;
  // Accept-to-result time without backpressure: a sample or tick visits every channel.
  localparam int SETTLE      = 2 + CHANNELS;
  localparam int PHASE_ITEMS = 275;

  typedef struct packed {
    logic [COUNT_W-1:0] cycle_count;
    logic               present;
    logic [TIME_W-1:0]  reading;
  } capture_result_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // [7:0] pin_levels, [15:8] timer_now, [18:16] channel
  logic [1:0]  s_axis_tuser  = '0;  // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [7:0] reading, [8] present, [24:9] cycle_count
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  multichannel_pulse_width_capture dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the configuration and of every channel.
  // ---------------------------------------------------------------------------
  cfg_t              model_cfg;
  logic [PIN_W-1:0]  prev_pins;
  logic [TIME_W-1:0] rise_stamp [CHANNELS];
  logic [TIME_W-1:0] width_reg  [CHANNELS];
  logic [CONF_W-1:0] conf_cnt   [CHANNELS];
  logic [COUNT_W-1:0] fall_count;

  capture_result_t pending_results[$];
  capture_result_t got_res;
  capture_result_t want_res;
  int error_count  = 0;
  int quiet_cycles = 0;

  // Stimulus knobs: no_idle holds both sides busy, tick_pct sets expiry tick density.
  bit no_idle  = 1'b0;
  int tick_pct = 3;

  // Random walk of the pin bus and timer, so that most samples form real pulses.
  logic [PIN_W-1:0]  walk_pins;
  logic [TIME_W-1:0] walk_timer;

  // Work out the result of one accepted beat and queue it.
  task automatic predict_capture(input cmd_e cmd, input logic [PIN_W-1:0] pins,
                                 input logic [TIME_W-1:0] timer,
                                 input logic [SEL_W-1:0] chan);
    logic [PIN_W-1:0] toggled;
    capture_result_t  res;
    int               i;
    res = '0;
    case (cmd)
      CMD_SAMPLE: begin
        // Every pin is remembered, but only the first CHANNELS pins make edges.
        toggled   = prev_pins ^ pins;
        prev_pins = pins;
        for (i = 0; i < CHANNELS; i++) begin
          if (toggled[i]) begin
            if (pins[i]) begin
              rise_stamp[i] = timer;
            end else begin
              // Width wraps to 8 bits after the centre offset comes off.
              width_reg[i] = timer - rise_stamp[i] - model_cfg.center_offset;
              // A lowered limit freezes the count where it stands.
              if (conf_cnt[i] < model_cfg.good_limit) conf_cnt[i] = conf_cnt[i] + 1'b1;
              if (i == 0) fall_count = fall_count + 1'b1;
            end
          end
        end
      end
      CMD_TICK: begin
        for (i = 0; i < CHANNELS; i++) begin
          if (conf_cnt[i] == 1) begin
            width_reg[i] = '0;
            conf_cnt[i]  = '0;
          end else if (conf_cnt[i] > 1) begin
            conf_cnt[i] = conf_cnt[i] - 1'b1;
          end
        end
      end
      CMD_READ: begin
        // A limit of 0 or 1 gives threshold 0, so every channel counts as present.
        res.reading = model_cfg.missing_code;
        if (chan < CHANNELS && conf_cnt[chan] >= (model_cfg.good_limit >> 1)) begin
          res.reading = width_reg[chan];
          res.present = 1'b1;
        end
      end
      default: begin
        // Unused command: state untouched, result still comes back.
      end
    endcase
    res.cycle_count = fall_count;
    pending_results.push_back(res);
  endtask

  // Drive one input beat, with an occasional gap first, and hold it until accepted.
  task automatic send_beat(input cmd_e cmd, input logic [PIN_W-1:0] pins,
                           input logic [TIME_W-1:0] timer, input logic [SEL_W-1:0] chan);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 24) gap = $urandom_range(12, 1);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, chan, timer, pins};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_capture(cmd, pins, timer, chan);
  endtask

  // Drop valid and hold off until every queued result has come back.
  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Register write in a setup phase, then an access phase; the model follows at the access edge.
  task automatic write_register(input reg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_CENTER:  model_cfg.center_offset = value[TIME_W-1:0];
      REG_LIMIT:   model_cfg.good_limit    = value[CONF_W-1:0];
      REG_MISSING: model_cfg.missing_code  = value[TIME_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reprogram all three registers once the block has gone quiet.
  task automatic configure(input logic [7:0] center, input logic [3:0] limit,
                           input logic [7:0] missing);
    wait_for_results();
    write_register(REG_CENTER, {24'b0, center});
    write_register(REG_LIMIT, {28'b0, limit});
    write_register(REG_MISSING, {24'b0, missing});
  endtask

  // One random beat: mostly clean pin toggles on a forward-running timer,
  // with noise samples, expiry ticks, reads and unused commands mixed in.
  task automatic random_item();
    int               pick;
    logic [PIN_W-1:0] flip;
    pick = $urandom_range(99);
    if (pick < 55) begin
      flip = PIN_W'(1) << $urandom_range(CHANNELS - 1);
      if ($urandom_range(2) == 0) flip = flip | (PIN_W'(1) << $urandom_range(CHANNELS - 1));
      walk_pins  = walk_pins ^ flip;
      walk_timer = walk_timer + TIME_W'($urandom_range(60, 1));
      send_beat(CMD_SAMPLE, walk_pins, walk_timer, SEL_W'($urandom));
    end else if (pick < 63) begin
      walk_pins  = PIN_W'($urandom);
      walk_timer = TIME_W'($urandom);
      send_beat(CMD_SAMPLE, walk_pins, walk_timer, SEL_W'($urandom));
    end else if (pick < 63 + tick_pct) begin
      send_beat(CMD_TICK, PIN_W'($urandom), TIME_W'($urandom), SEL_W'($urandom));
    end else if (pick < 96) begin
      send_beat(CMD_READ, PIN_W'($urandom), TIME_W'($urandom), SEL_W'($urandom));
    end else begin
      send_beat(CMD_NONE, PIN_W'($urandom), TIME_W'($urandom), SEL_W'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------

  // Fresh from reset: nothing present, tick on empty counts, unused command leaves pins alone.
  task automatic test_reset_state();
    send_beat(CMD_READ, 8'h00, 8'h00, 3'd0);
    send_beat(CMD_TICK, 8'h00, 8'h00, 3'd0);
    send_beat(CMD_NONE, 8'hFF, 8'hFF, 3'd7);
  endtask

  // All channels pulse together at the timer extremes, across the wrap and at zero width.
  task automatic test_pulse_extremes();
    send_beat(CMD_SAMPLE, 8'hFF, 8'd0,   3'd0);
    send_beat(CMD_SAMPLE, 8'h00, 8'd255, 3'd7);
    send_beat(CMD_SAMPLE, 8'hFF, 8'd250, 3'd0);
    send_beat(CMD_SAMPLE, 8'h00, 8'd5,   3'd0);
    send_beat(CMD_SAMPLE, 8'hFF, 8'd255, 3'd0);
    send_beat(CMD_SAMPLE, 8'h00, 8'd0,   3'd0);
    send_beat(CMD_SAMPLE, 8'hFF, 8'd100, 3'd0);
    send_beat(CMD_SAMPLE, 8'h00, 8'd123, 3'd0);
    send_beat(CMD_READ,   8'h00, 8'h00,  3'd0);
    send_beat(CMD_READ,   8'hFF, 8'hFF,  3'd7);
    // Drop one step of confidence: now below half the limit.
    send_beat(CMD_TICK,   8'h00, 8'h00,  3'd0);
    send_beat(CMD_READ,   8'h00, 8'h00,  3'd3);
  endtask

  // Register extremes: top limit, limit under the count, tiny limits, both offset ends.
  task automatic test_register_extremes();
    int k;
    configure(8'd0, 4'd15, 8'd127);
    send_beat(CMD_SAMPLE, 8'h01, 8'd0,   3'd0);
    send_beat(CMD_SAMPLE, 8'h00, 8'd127, 3'd0);
    send_beat(CMD_READ,   8'h00, 8'h00,  3'd0);
    configure(8'd255, 4'd2, 8'h80);
    send_beat(CMD_SAMPLE, 8'h80, 8'd0,   3'd0);
    send_beat(CMD_SAMPLE, 8'h00, 8'd0,   3'd0);
    send_beat(CMD_READ,   8'h00, 8'h00,  3'd7);
    configure(8'd255, 4'd0, 8'h80);
    for (k = 0; k < 4; k++) send_beat(CMD_TICK, 8'h00, 8'h00, 3'd0);
    send_beat(CMD_READ,   8'h00, 8'h00,  3'd5);
    configure(8'd23, 4'd1, 8'h55);
    send_beat(CMD_READ,   8'h00, 8'h00,  3'd2);
  endtask

  // Random traffic over several register settings; one phase runs with no idling,
  // and one pauses the sender mid-way until every result is back.
  task automatic test_random_traffic();
    int phase;
    int n;
    walk_pins  = prev_pins;
    walk_timer = '0;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          configure(CENTER_RST, LIMIT_RST, MISSING_RST);
          tick_pct = 3;
        end
        1: begin
          configure(8'd0, 4'd15, 8'd127);
          tick_pct = 2;
        end
        2: begin
          configure(8'd255, 4'd2, 8'd0);
          tick_pct = 6;
        end
        3: begin
          configure(8'($urandom), 4'd0, 8'($urandom));
          tick_pct = 4;
        end
        4: begin
          configure(8'($urandom), 4'd1, 8'($urandom));
          tick_pct = 8;
        end
        default: begin
          configure(8'($urandom), 4'($urandom_range(15, 2)), 8'($urandom));
          tick_pct = 3;
        end
      endcase
      no_idle = (phase == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 5 && n == PHASE_ITEMS / 2) wait_for_results();
        random_item();
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure, checker, watchdog.
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 24);
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = m_axis_tdata[24:0];
      if (pending_results.size() == 0) begin
        if (error_count < 10)
          $display("unexpected result beat: reading %0d present %0b count %0d",
                   $signed(got_res.reading), got_res.present, got_res.cycle_count);
        error_count++;
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.reading !== want_res.reading || got_res.present !== want_res.present ||
            got_res.cycle_count !== want_res.cycle_count) begin
          if (error_count < 10)
            $display("mismatch: expected reading %0d present %0b count %0d, got %0d %0b %0d",
                     $signed(want_res.reading), want_res.present, want_res.cycle_count,
                     $signed(got_res.reading), got_res.present, got_res.cycle_count);
          error_count++;
        end
      end
    end
  end

  // Count cycles with no progress on any port.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("FAIL multichannel_pulse_width_capture");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    model_cfg.center_offset = CENTER_RST;
    model_cfg.good_limit    = LIMIT_RST;
    model_cfg.missing_code  = MISSING_RST;
    prev_pins  = '0;
    fall_count = '0;
    foreach (rise_stamp[c]) begin
      rise_stamp[c] = '0;
      width_reg[c]  = '0;
      conf_cnt[c]   = '0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_pulse_extremes();
    test_register_extremes();
    test_random_traffic();

    wait_for_results();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS multichannel_pulse_width_capture");
    end else begin
      $display("FAIL multichannel_pulse_width_capture");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/mpwc_pkg.sv
hw/rtl/mpwc_cfg.sv
hw/rtl/mpwc_alu.sv
hw/rtl/multichannel_pulse_width_capture.sv
sim/testbench.sv
